// ===== hdl/complex_fir_filter_assert.svh =====
// Assertion macros used by the top-level filter RTL.
`ifndef COMPLEX_FIR_FILTER_ASSERT_SVH
`define COMPLEX_FIR_FILTER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CFF_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CFF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cff_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cff_pkg;

  localparam int MAX_TAPS_DEF = 64;
  localparam int TAPS_RESET   = 64;
  localparam int CFG_W        = 7;
  localparam int DATA_W       = 16;
  localparam int FRAC_W       = 15;
  localparam int IDX_W        = 6;
  localparam int PROD_W       = 2 * DATA_W;

  // Input tdata: sample_re, sample_im, coef_index, coef_re, coef_im, zero pad
  localparam int OFS_S_IM     = DATA_W;
  localparam int OFS_IDX      = 2 * DATA_W;
  localparam int OFS_C_RE     = OFS_IDX + IDX_W;
  localparam int OFS_C_IM     = OFS_C_RE + DATA_W;
  localparam int S_FIELDS_W   = OFS_C_IM + DATA_W;
  localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W    = 2 * DATA_W;

  localparam logic OP_FILTER  = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Control that travels alongside the registered memory read data
  typedef struct packed {
    logic start;
    logic valid;
    logic last;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/cff_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cff_mac #(
  parameter int MAX_TAPS = cff_pkg::MAX_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cff_pkg::mac_ctrl_t            ctrl,
  input  logic [2*cff_pkg::DATA_W-1:0]  smp,
  input  logic [2*cff_pkg::DATA_W-1:0]  tap,
  output logic                          done,
  output logic [cff_pkg::DATA_W-1:0]    res_re,
  output logic [cff_pkg::DATA_W-1:0]    res_im
);
  import cff_pkg::*;

  localparam int ACC_W = PROD_W + 1 + $clog2(MAX_TAPS);
  localparam logic signed [ACC_W:0] RND    = (ACC_W+1)'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [ACC_W:0] SAT_LO = ~SAT_HI;

  logic signed [DATA_W-1:0] sr, si, cr, ci;
  logic signed [PROD_W-1:0] pr_rr, pr_ii, pr_ri, pr_ir;
  logic                     p_valid, p_last;
  logic signed [ACC_W-1:0]  acc_re, acc_im;

  function automatic logic [DATA_W-1:0] sat_round(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] v;
    logic signed [ACC_W:0] q;
    v = (ACC_W+1)'(a) + RND;
    q = v >>> FRAC_W;
    if (q > SAT_HI) begin
      return SAT_HI[DATA_W-1:0];
    end else if (q < SAT_LO) begin
      return SAT_LO[DATA_W-1:0];
    end
    return q[DATA_W-1:0];
  endfunction

  assign sr = signed'(smp[DATA_W-1:0]);
  assign si = signed'(smp[2*DATA_W-1:DATA_W]);
  assign cr = signed'(tap[DATA_W-1:0]);
  assign ci = signed'(tap[2*DATA_W-1:DATA_W]);

  // Stage 1: four partial products of the complex multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_last  <= 1'b0;
    end else begin
      p_valid <= ctrl.valid;
      p_last  <= ctrl.last;
    end
    pr_rr <= sr * cr;
    pr_ii <= si * ci;
    pr_ri <= sr * ci;
    pr_ir <= si * cr;
  end

  // Stage 2: accumulate at full width
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else if (ctrl.start) begin
      done <= 1'b0;
    end else if (p_valid && p_last) begin
      done <= 1'b1;
    end
    if (ctrl.start) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (p_valid) begin
      acc_re <= acc_re + ACC_W'(pr_rr) - ACC_W'(pr_ii);
      acc_im <= acc_im + ACC_W'(pr_ri) + ACC_W'(pr_ir);
    end
  end

  assign res_re = sat_round(acc_re);
  assign res_im = sat_round(acc_im);

endmodule

`default_nettype wire

// ===== hdl/complex_fir_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "complex_fir_filter_assert.svh"

// Channel  Signals                                   Moves
// -------  ----------------------------------------  ------------------------------
// cfg      cfg_we, cfg_data                          taps_in_use write
// s_*      s_tvalid, s_tready, s_tdata, s_tuser      sample or coefficient load
// m_*      m_tvalid, m_tready, m_tdata               filtered sample
//
// A sample transaction runs one complex MAC per tap through a single shared
// multiply-accumulate unit, fed through registered memory reads.
// A coefficient load gives no output transaction.
// After reset a clearing pass zeroes both stores; s_tready stays low
// meanwhile, configuration writes are taken as usual.
// A result waits in the output register; a stalled m_tready holds the next result.

module complex_fir_filter #(
  parameter int MAX_TAPS = cff_pkg::MAX_TAPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cff_pkg::CFG_W-1:0]      cfg_data,   // taps_in_use
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // sample_re, sample_im, coef_index, coef_re, coef_im, zero pad
  input  logic [cff_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                           s_tuser,    // opcode
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cff_pkg::M_TDATA_W-1:0]  m_tdata     // out_re, out_im
);
  import cff_pkg::*;

  localparam int AW       = $clog2(MAX_TAPS);
  localparam int CW       = ((AW > CFG_W) ? AW : CFG_W) + 1;
  localparam int TAPS_RST = (MAX_TAPS < TAPS_RESET) ? MAX_TAPS : TAPS_RESET;

  state_t state, state_next;

  logic [CFG_W-1:0]    ntaps, cfg_taps;
  logic [AW-1:0]       wptr, p_cur, wptr_after, last_idx;
  logic [AW-1:0]       j, clr_addr;
  logic [CW-1:0]       kcnt, p_inc;
  logic [2*DATA_W-1:0] ring_mem [MAX_TAPS];
  logic [2*DATA_W-1:0] tap_mem  [MAX_TAPS];
  logic [2*DATA_W-1:0] ring_q, tap_q;
  logic [IDX_W-1:0]    in_idx;
  logic                acc_sample, acc_load, load_ok;
  logic                clearing, issuing, issue_last, out_load;
  mac_ctrl_t           rd_ctrl;
  logic                mac_done;
  logic [DATA_W-1:0]   res_re, res_im;

  assign in_idx     = s_tdata[OFS_C_RE-1:OFS_IDX];
  assign acc_sample = s_tvalid && s_tready && (s_tuser == OP_FILTER);
  assign acc_load   = s_tvalid && s_tready && (s_tuser == OP_LOAD);
  assign load_ok    = int'(in_idx) < MAX_TAPS;

  assign cfg_taps = (cfg_data == '0) ? CFG_W'(1) :
                    (int'(cfg_data) > MAX_TAPS) ? CFG_W'(MAX_TAPS) : cfg_data;

  assign p_cur      = (CW'(wptr) >= CW'(ntaps)) ? '0 : wptr;
  assign p_inc      = CW'(p_cur) + CW'(1);
  assign wptr_after = (p_inc >= CW'(ntaps)) ? '0 : p_inc[AW-1:0];
  assign last_idx   = AW'(CW'(ntaps) - CW'(1));

  // Outputs of the sequencer
  always_comb begin
    s_tready   = (state == ST_IDLE);
    clearing   = (state == ST_CLEAR);
    issuing    = (state == ST_RUN);
    issue_last = issuing && (kcnt == CW'(CW'(ntaps) - CW'(1)));
    out_load   = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == AW'(MAX_TAPS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (acc_sample) state_next = ST_RUN;
      ST_RUN:   if (issue_last) state_next = ST_DRAIN;
      ST_DRAIN: if (mac_done) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      ntaps    <= CFG_W'(TAPS_RST);
      wptr     <= '0;
      j        <= '0;
      kcnt     <= '0;
      rd_ctrl  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_we) begin
        ntaps <= cfg_taps;
        wptr  <= '0;
      end else if (acc_sample) begin
        wptr <= wptr_after;
      end
      // Walk the ring backwards from the newest sample, wrapping at the tap count
      if (acc_sample) begin
        j    <= p_cur;
        kcnt <= '0;
      end else if (issuing && !issue_last) begin
        kcnt <= kcnt + CW'(1);
        j    <= (j == '0) ? last_idx : j - AW'(1);
      end
      rd_ctrl.start <= acc_sample;
      rd_ctrl.valid <= issuing;
      rd_ctrl.last  <= issue_last;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {res_im, res_re};
    end
  end

  // Sample ring
  always_ff @(posedge clk) begin
    if (clearing) begin
      ring_mem[clr_addr] <= '0;
    end else if (acc_sample) begin
      ring_mem[p_cur] <= s_tdata[2*DATA_W-1:0];
    end
    ring_q <= ring_mem[j];
  end

  // Tap store
  always_ff @(posedge clk) begin
    if (clearing) begin
      tap_mem[clr_addr] <= '0;
    end else if (acc_load && load_ok) begin
      tap_mem[AW'(in_idx)] <= s_tdata[OFS_C_IM+DATA_W-1:OFS_C_RE];
    end
    tap_q <= tap_mem[kcnt[AW-1:0]];
  end

  cff_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (rd_ctrl),
    .smp    (ring_q),
    .tap    (tap_q),
    .done   (mac_done),
    .res_re (res_re),
    .res_im (res_im)
  );

  `CFF_ASSERT_IMPLY(a_wptr_below_taps, clk, rst, state == ST_IDLE,
    CW'(wptr) < CW'(ntaps), "write pointer outside the ring in use")
  `CFF_ASSERT_IMPLY(a_taps_in_range, clk, rst, 1'b1,
    (ntaps != '0) && (CW'(ntaps) <= CW'(MAX_TAPS)), "tap count out of range")
  `CFF_ASSERT_NEXT(a_sample_starts_run, clk, rst, acc_sample,
    (state == ST_RUN) && rd_ctrl.start, "sample transaction did not start the MAC walk")
  `CFF_ASSERT_IMPLY(a_done_after_drain, clk, rst, mac_done && !$past(mac_done),
    $past(state) == ST_DRAIN, "accumulation finished outside the drain phase")

endmodule

`default_nettype wire
